// ----- hdl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, widths and verdict codes for the sphere/frustum classifier.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // plane set: six frustum planes plus the user far plane
  localparam int NUM_PLANES   = 7;
  localparam int USER_FAR_IDX = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // fixed-point widths
  localparam int COORD_W    = 16;  // Q12.4 positions, Q1.14 normals
  localparam int RADIUS_W   = 15;  // unsigned Q11.4
  localparam int FRAC_SHIFT = 14;  // Q.4 -> Q.18
  localparam int PROD_W     = 2 * COORD_W;
  localparam int DIST_W     = PROD_W + 3;  // sum of three products minus distance

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_INSIDE   = 2'd0;
  localparam verdict_t VERDICT_BOUNDARY = 2'd1;
  localparam verdict_t VERDICT_OUTSIDE  = 2'd2;

  // one plane register: nx in the low bits, plane distance in the top bits
  typedef struct packed {
    logic signed [COORD_W-1:0] offset;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

endpackage

// ----- hdl/sphere_frustum_classifier_top.sv -----
// ----------------------------------------------------------------------------
// sphere_frustum_classifier_top
// Classifies a bounding sphere against the user far plane and, in mode 0,
// the six frustum planes: inside, boundary or outside.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: center xyz, radius; tuser: mode
//  out_     master     out_tvalid/out_tready tdata: verdict
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data (one plane)
//
//  Four register stages: input, 21 products, plane distances, verdict.
//  One sphere per cycle while out_tready does not stall the verdict register.
//  Each stage loads when empty or when the stage after it moves, so bubbles
//  are filled while a verdict waits at the output.
//  Reset clears the stage valid bits and sets every plane to zero.
//  cfg_ready is always high; writes to index 7 are dropped.
// ----------------------------------------------------------------------------
module sphere_frustum_classifier_top
  import sfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input spheres
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // center_x, center_y, center_z, radius, pad
  input  logic                  in_tuser,   // mode
  // verdicts
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // verdict, pad
  // plane registers
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // plane registers
  plane_t plane_r [NUM_PLANES];

  // stage valids and load enables
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic en1, en2, en3, en4;

  // stage 1: input register
  logic                       s1_mode_r;
  logic signed [COORD_W-1:0]  s1_cx_r, s1_cy_r, s1_cz_r;
  logic [RADIUS_W-1:0]        s1_radius_r;

  // stage 2: products
  logic signed [PROD_W-1:0]   s2_px_r [NUM_PLANES];
  logic signed [PROD_W-1:0]   s2_py_r [NUM_PLANES];
  logic signed [PROD_W-1:0]   s2_pz_r [NUM_PLANES];
  logic                       s2_mode_r;
  logic [RADIUS_W-1:0]        s2_radius_r;

  // stage 3: signed plane distances in Q.18
  logic signed [DIST_W-1:0]   s3_d_r [NUM_PLANES];
  logic signed [DIST_W-1:0]   s3_d_nxt [NUM_PLANES];
  logic                       s3_mode_r;
  logic [RADIUS_W-1:0]        s3_radius_r;

  // stage 4: verdict
  verdict_t                   out_verdict_r, out_verdict_nxt;

  // pipeline flow control
  assign en4 = !out_vld_r || out_tready;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;

  assign in_tready  = en1;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_verdict_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r  <= in_tvalid;
      if (en2) s2_vld_r  <= s1_vld_r;
      if (en3) s3_vld_r  <= s2_vld_r;
      if (en4) out_vld_r <= s3_vld_r;
    end
  end

  // plane register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
      plane_r[cfg_index] <= plane_t'(cfg_data);
    end
  end

  // stage 1: capture the sphere
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode_r   <= in_tuser;
      s1_cx_r     <= in_tdata[COORD_W-1:0];
      s1_cy_r     <= in_tdata[2*COORD_W-1:COORD_W];
      s1_cz_r     <= in_tdata[3*COORD_W-1:2*COORD_W];
      s1_radius_r <= in_tdata[3*COORD_W+RADIUS_W-1:3*COORD_W];
    end
  end

  // stage 2: center times normal, one multiplier per axis per plane
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        s2_px_r[p] <= s1_cx_r * plane_r[p].nx;
        s2_py_r[p] <= s1_cy_r * plane_r[p].ny;
        s2_pz_r[p] <= s1_cz_r * plane_r[p].nz;
      end
      s2_mode_r   <= s1_mode_r;
      s2_radius_r <= s1_radius_r;
    end
  end

  // stage 3: d = dot(center, normal) - distance, all in Q.18
  always_comb begin
    logic signed [DIST_W-1:0] dist_ext;
    for (int p = 0; p < NUM_PLANES; p++) begin
      dist_ext    = DIST_W'(plane_r[p].offset);
      s3_d_nxt[p] = DIST_W'(s2_px_r[p]) + DIST_W'(s2_py_r[p]) + DIST_W'(s2_pz_r[p])
                    - (dist_ext <<< FRAC_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        s3_d_r[p] <= s3_d_nxt[p];
      end
      s3_mode_r   <= s2_mode_r;
      s3_radius_r <= s2_radius_r;
    end
  end

  // stage 4: compare against +/- radius and merge the tested planes
  always_comb begin
    logic signed [DIST_W-1:0] r_pos;
    logic signed [DIST_W-1:0] r_neg;
    logic                     any_out;
    logic                     any_bnd;
    logic                     tested;
    r_pos   = $signed({{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, s3_radius_r,
                       {FRAC_SHIFT{1'b0}}});
    r_neg   = -r_pos;
    any_out = 1'b0;
    any_bnd = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      // mode 1 keeps only the user far plane
      tested  = !s3_mode_r || (p == USER_FAR_IDX);
      any_out = any_out | (tested && (s3_d_r[p] > r_pos));
      any_bnd = any_bnd | (tested && (s3_d_r[p] > r_neg));
    end
    if (any_out) begin
      out_verdict_nxt = VERDICT_OUTSIDE;
    end else if (any_bnd) begin
      out_verdict_nxt = VERDICT_BOUNDARY;
    end else begin
      out_verdict_nxt = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_verdict_r <= out_verdict_nxt;
    end
  end

endmodule

// ----- hdl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level assertions for the sphere/frustum classifier, bound to the top.
// ----------------------------------------------------------------------------
module sfc_checker
  import sfc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_ready
);

  // verdict code is always one of the three defined codes
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == VERDICT_INSIDE ||
                    out_tdata[1:0] == VERDICT_BOUNDARY ||
                    out_tdata[1:0] == VERDICT_OUTSIDE))
    else $error("sfc: undefined verdict code");

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("sfc: stalled output word changed");

  // no verdict out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("sfc: output valid right after reset");

  // a draining output never blocks the input side
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> (in_tready && cfg_ready))
    else $error("sfc: input stalled while output drains");

endmodule

bind sphere_frustum_classifier_top sfc_checker u_sfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
